FILE: src/epm_pkg.sv
// edge point pair merger: shared constants, state codes and handshake types
// depends on nothing; imported by every module of the block
package epm_pkg;

    // width of the merge distance register
    localparam int MD_WIDTH = 31;

    // front queue depth and pointer width
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // back sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DINIT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MID   = 4'd7;
    localparam logic [3:0] S_MID2  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_DRAIN = 4'd10;

    // queue head status seen by the back end
    typedef struct packed {
        logic avail;
        logic last;
    } t_q_stat;

endpackage

FILE: src/epm_front.sv
// edge point pair merger front end: accepts points and queues them
// depends on epm_pkg
module epm_front import epm_pkg::*; #(
    parameter int PW = 32,
    parameter int NW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [PW-1:0] i_pos [3],
    input  logic signed [NW-1:0] i_nrm [3],
    input  logic                 i_last,
    output t_q_stat              o_stat,
    output logic signed [PW-1:0] o_pos [3],
    output logic signed [NW-1:0] o_nrm [3],
    input  logic                 i_pop
);

    logic signed [PW-1:0] r_pos  [Q_DEPTH][3];
    logic signed [NW-1:0] r_nrm  [Q_DEPTH][3];
    logic                 r_last [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp, r_rp;
    logic [Q_PTR_W:0]     r_cnt;
    logic                 w_push, w_pop;

    // transaction accept and head pop
    assign o_stall = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && o_stat.avail;

    // head of queue, classified by end of segment marker
    assign o_stat.avail = (r_cnt != '0);
    assign o_stat.last  = r_last[r_rp];
    assign o_pos        = r_pos[r_rp];
    assign o_nrm        = r_nrm[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_pos[r_wp]  <= i_pos;
            r_nrm[r_wp]  <= i_nrm;
            r_last[r_wp] <= i_last;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: src/epm_back.sv
// edge point pair merger back end: distance test, midpoint, normal
// renormalization by serial square root and division, result buffer; uses epm_pkg
module epm_back import epm_pkg::*; #(
    parameter int PW   = 32,
    parameter int NW   = 16,
    parameter int CNTW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_stat               i_qstat,
    input  logic signed [PW-1:0]  i_qpos [3],
    input  logic signed [NW-1:0]  i_qnrm [3],
    output logic                  o_qpop,
    input  logic [MD_WIDTH-1:0]   i_md,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [PW-1:0]  o_pos [3],
    output logic signed [NW-1:0]  o_nrm [3],
    output logic                  o_run_end,
    output logic                  o_seg_done,
    output logic [CNTW-1:0]       o_count
);

    localparam int CW = (PW + 1 > MD_WIDTH) ? PW + 1 : MD_WIDTH;
    localparam int MW = (NW + 1 > MD_WIDTH) ? NW + 1 : MD_WIDTH;
    localparam int AW = 2 * MW + 2;
    localparam int QW = 2 * NW + 4;
    localparam int IW = $clog2(NW + 1);
    localparam logic [NW-1:0] ONE = NW'(1) << (NW - 2);

    logic [3:0]             r_state;
    logic signed [PW-1:0]   r_cp [3], r_prev_p [3], r_last_em [3], r_mp [3];
    logic signed [NW-1:0]   r_cn [3], r_prev_n [3], r_mn [3];
    logic                   r_last, r_have, r_cons, r_first, r_next_cons;
    logic [CNTW-1:0]        r_count;
    logic [MD_WIDTH-1:0]    r_d [3];
    logic signed [NW:0]     r_s [3];
    logic                   r_mode;
    logic [1:0]             r_idx;
    logic [2*MW-1:0]        r_prod;
    logic [AW-1:0]          r_acc;
    logic [QW-1:0]          r_v, r_r, r_b;
    logic [NW:0]            r_L;
    logic [NW+2:0]          r_rem;
    logic [NW-1:0]          r_q;
    logic [IW-1:0]          r_it;
    logic signed [PW-1:0]   r_bp [3][3];
    logic signed [NW-1:0]   r_bn [3][3];
    logic [1:0]             r_nout, r_k;
    logic                   r_ovalid, r_orun, r_oseg;
    logic signed [PW-1:0]   r_op [3];
    logic signed [NW-1:0]   r_on [3];
    logic [CNTW-1:0]        r_ocnt;

    logic [CW-1:0]          w_dabs [3];
    logic signed [PW:0]     w_diff [3], w_msum [3];
    logic signed [PW-1:0]   w_mid [3];
    logic signed [NW:0]     w_nsum [3];
    logic                   w_far_any;
    logic signed [NW:0]     w_s_sel;
    logic [NW:0]            w_abs_s;
    logic [MW-1:0]          w_sq_in;
    logic [AW-1:0]          n_acc;
    logic [QW-1:0]          w_rb, n_r;
    logic [2*NW:0]          w_num;
    logic [NW+1:0]          w_den;
    logic [NW+2:0]          w_t;
    logic                   w_ge;
    logic [NW-1:0]          n_q, w_sat, w_res;
    logic                   w_push;
    logic signed [PW-1:0]   w_push_p [3];
    logic signed [NW-1:0]   w_push_n [3];
    logic [1:0]             n_nout;
    logic                   w_fin_push, w_out_free, w_drain_last, w_finish;
    logic                   w_dist_far, w_mp_diff, w_cp_new;

    // per axis differences, midpoints and normal sums
    always_comb begin
        w_far_any = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = {r_cp[i][PW-1], r_cp[i]} - {r_prev_p[i][PW-1], r_prev_p[i]};
            w_dabs[i] = CW'(w_diff[i][PW] ? (~w_diff[i] + 1'b1) : w_diff[i]);
            if (w_dabs[i] > CW'(i_md)) w_far_any = 1'b1;
            w_msum[i] = {r_cp[i][PW-1], r_cp[i]} + {r_prev_p[i][PW-1], r_prev_p[i]};
            w_mid[i]  = w_msum[i][PW:1];
            w_nsum[i] = {r_cn[i][NW-1], r_cn[i]} + {r_prev_n[i][NW-1], r_prev_n[i]};
        end
    end

    assign w_mp_diff = (w_mid[0] != r_prev_p[0]) || (w_mid[1] != r_prev_p[1])
                    || (w_mid[2] != r_prev_p[2]);

    // shared squaring unit operand
    always_comb begin
        case (r_idx)
            2'd0:    w_s_sel = r_s[0];
            2'd1:    w_s_sel = r_s[1];
            default: w_s_sel = r_s[2];
        endcase
        w_abs_s = w_s_sel[NW] ? (~w_s_sel + 1'b1) : w_s_sel;
        if (r_mode) begin
            w_sq_in = MW'(w_abs_s);
        end else begin
            case (r_idx)
                2'd0:    w_sq_in = MW'(r_d[0]);
                2'd1:    w_sq_in = MW'(r_d[1]);
                2'd2:    w_sq_in = MW'(r_d[2]);
                default: w_sq_in = MW'(i_md);
            endcase
        end
    end

    assign n_acc      = r_acc + AW'(r_prod);
    assign w_dist_far = (r_acc > AW'(r_prod));

    // square root step, two bits of radicand per cycle
    assign w_rb = r_r + r_b;
    assign n_r  = (r_v >= w_rb) ? ((r_r >> 1) + r_b) : (r_r >> 1);

    // restoring division step, one quotient bit per cycle
    assign w_num = ((2*NW+1)'(w_abs_s) << (NW - 1)) + (2*NW+1)'(r_L);
    assign w_den = {r_L, 1'b0};
    assign w_t   = {r_rem[NW+1:0], r_q[NW-1]};
    assign w_ge  = (w_t >= (NW+3)'(w_den));
    assign n_q   = {r_q[NW-2:0], w_ge};
    assign w_sat = (n_q > ONE) ? ONE : n_q;
    assign w_res = w_s_sel[NW] ? (~w_sat + 1'b1) : w_sat;

    // final point of segment goes out unless it repeats the last emitted one
    assign w_cp_new = (r_cp[0] != r_last_em[0]) || (r_cp[1] != r_last_em[1])
                   || (r_cp[2] != r_last_em[2]);
    assign w_fin_push = r_last && (!r_have || w_cp_new);

    // result buffer writes
    always_comb begin
        w_push   = 1'b0;
        w_push_p = r_prev_p;
        w_push_n = r_prev_n;
        case (r_state)
            S_DIFF:  w_push = w_far_any;
            S_ACC:   w_push = !r_mode && (r_idx == 2'd3) && w_dist_far;
            S_MID:   w_push = r_first && w_mp_diff;
            S_MID2: begin
                w_push   = 1'b1;
                w_push_p = r_mp;
                w_push_n = r_mn;
            end
            S_FIN: begin
                w_push   = w_fin_push;
                w_push_p = r_cp;
                w_push_n = r_cn;
            end
            default: w_push = 1'b0;
        endcase
    end

    assign n_nout       = r_nout + 2'(w_push);
    assign w_out_free   = !r_ovalid || !i_stall;
    assign w_drain_last = (r_k == r_nout - 2'd1);
    assign w_finish     = ((r_state == S_FIN) && (n_nout == 2'd0))
                       || ((r_state == S_DRAIN) && w_out_free && w_drain_last);
    assign o_qpop       = (r_state == S_IDLE) && i_qstat.avail;

    // result buffer storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_bp[r_nout] <= w_push_p;
            r_bn[r_nout] <= w_push_n;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_have    <= 1'b0;
            r_cons    <= 1'b0;
            r_first   <= 1'b1;
            r_count   <= '0;
            r_nout    <= '0;
            r_ovalid  <= 1'b0;
            r_last_em <= '{default: '0};
        end else begin
            if (r_ovalid && !i_stall && (r_state != S_DRAIN)) r_ovalid <= 1'b0;
            if (w_push) begin
                r_nout    <= n_nout;
                r_last_em <= w_push_p;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_qstat.avail) begin
                        r_cp        <= i_qpos;
                        r_cn        <= i_qnrm;
                        r_last      <= i_qstat.last;
                        r_nout      <= '0;
                        r_next_cons <= 1'b0;
                        r_state     <= (r_have && !r_cons) ? S_DIFF : S_FIN;
                    end
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) r_d[i] <= w_dabs[i][MD_WIDTH-1:0];
                    if (w_far_any) begin
                        r_first <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_mode  <= 1'b0;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_sq_in * w_sq_in;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_mode && (r_idx == 2'd3)) begin
                        if (w_dist_far) begin
                            r_first <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_mp        <= w_mid;
                            r_s         <= w_nsum;
                            r_next_cons <= 1'b1;
                            if (r_count != {CNTW{1'b1}}) r_count <= r_count + 1'b1;
                            r_mode      <= 1'b1;
                            r_idx       <= '0;
                            r_acc       <= '0;
                            r_state     <= S_MUL;
                        end
                    end else if (r_mode && (r_idx == 2'd2)) begin
                        if (n_acc == '0) begin
                            r_mn    <= '{default: '0};
                            r_state <= S_MID;
                        end else begin
                            r_v     <= n_acc[QW-1:0];
                            r_r     <= '0;
                            r_b     <= QW'(1) << (QW - 2);
                            r_state <= S_SQRT;
                        end
                    end else begin
                        r_acc   <= n_acc;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_SQRT: begin
                    if (r_v >= w_rb) r_v <= r_v - w_rb;
                    r_r <= n_r;
                    r_b <= r_b >> 2;
                    if (r_b == QW'(1)) begin
                        r_L     <= n_r[NW:0];
                        r_idx   <= '0;
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_rem   <= (NW+3)'(w_num[2*NW:NW]);
                    r_q     <= w_num[NW-1:0];
                    r_it    <= IW'(NW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? (w_t - (NW+3)'(w_den)) : w_t;
                    r_q   <= n_q;
                    r_it  <= r_it - 1'b1;
                    if (r_it == IW'(1)) begin
                        r_mn[r_idx] <= w_res;
                        if (r_idx == 2'd2) begin
                            r_state <= S_MID;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DINIT;
                        end
                    end
                end
                S_MID: begin
                    r_first <= 1'b0;
                    r_state <= S_MID2;
                end
                S_MID2: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_k     <= '0;
                    r_state <= (n_nout == 2'd0) ? S_IDLE : S_DRAIN;
                end
                S_DRAIN: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_op     <= r_bp[r_k];
                        r_on     <= r_bn[r_k];
                        r_orun   <= w_drain_last;
                        r_oseg   <= w_drain_last && r_last;
                        r_ocnt   <= r_count;
                        r_k      <= r_k + 1'b1;
                        if (w_drain_last) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // end of item: store the point or close the segment
            if (w_finish) begin
                if (r_last) begin
                    r_have  <= 1'b0;
                    r_cons  <= 1'b0;
                    r_first <= 1'b1;
                    r_count <= '0;
                end else begin
                    r_prev_p <= r_cp;
                    r_prev_n <= r_cn;
                    r_have   <= 1'b1;
                    r_cons   <= r_next_cons;
                end
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_pos      = r_op;
    assign o_nrm      = r_on;
    assign o_run_end  = r_orun;
    assign o_seg_done = r_oseg;
    assign o_count    = r_ocnt;

endmodule

FILE: src/edge_point_pair_merger_unit.sv
// edge point pair merger top level: config register, front queue, back sequencer
// depends on epm_pkg, epm_front, epm_back
//
//   channel   handshake                   payload
//   input     i_valid / o_stall           i_in_x..i_in_nz, i_segment_last
//   output    o_valid / i_stall           o_out_x..o_out_nz, o_run_end,
//                                         o_segment_done, o_merged_total
//   config    i_cfg_valid / o_cfg_ready   i_cfg_data (merge distance)
//
// the back sequencer handles one point at a time; a two entry queue takes
// points while it works and an output register holds results under stall.
// a far pair is caught by a per axis compare or else by the squared sum.
// a merge runs a serial square root (NORMAL_WIDTH+2 steps) then three serial
// divides; with a zero normal sum both are skipped.
// each result passes through the output register.
// reset is synchronous; merge distance resets to zero.
module edge_point_pair_merger_unit import epm_pkg::*; #(
    parameter int POSITION_WIDTH = 32,
    parameter int NORMAL_WIDTH   = 16,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [POSITION_WIDTH-1:0] i_in_x,
    input  logic signed [POSITION_WIDTH-1:0] i_in_y,
    input  logic signed [POSITION_WIDTH-1:0] i_in_z,
    input  logic signed [NORMAL_WIDTH-1:0]   i_in_nx,
    input  logic signed [NORMAL_WIDTH-1:0]   i_in_ny,
    input  logic signed [NORMAL_WIDTH-1:0]   i_in_nz,
    input  logic                             i_segment_last,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [POSITION_WIDTH-1:0] o_out_x,
    output logic signed [POSITION_WIDTH-1:0] o_out_y,
    output logic signed [POSITION_WIDTH-1:0] o_out_z,
    output logic signed [NORMAL_WIDTH-1:0]   o_out_nx,
    output logic signed [NORMAL_WIDTH-1:0]   o_out_ny,
    output logic signed [NORMAL_WIDTH-1:0]   o_out_nz,
    output logic                             o_run_end,
    output logic                             o_segment_done,
    output logic [COUNT_WIDTH-1:0]           o_merged_total,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [MD_WIDTH-1:0]              i_cfg_data
);

    logic [MD_WIDTH-1:0]             r_merge_dist;
    logic signed [POSITION_WIDTH-1:0] w_in_pos [3], w_q_pos [3], w_o_pos [3];
    logic signed [NORMAL_WIDTH-1:0]   w_in_nrm [3], w_q_nrm [3], w_o_nrm [3];
    t_q_stat                          w_qstat;
    logic                             w_qpop;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_dist <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_merge_dist <= i_cfg_data;
        end
    end

    assign w_in_pos[0] = i_in_x;
    assign w_in_pos[1] = i_in_y;
    assign w_in_pos[2] = i_in_z;
    assign w_in_nrm[0] = i_in_nx;
    assign w_in_nrm[1] = i_in_ny;
    assign w_in_nrm[2] = i_in_nz;

    // front queue
    epm_front #(
        .PW (POSITION_WIDTH),
        .NW (NORMAL_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pos   (w_in_pos),
        .i_nrm   (w_in_nrm),
        .i_last  (i_segment_last),
        .o_stat  (w_qstat),
        .o_pos   (w_q_pos),
        .o_nrm   (w_q_nrm),
        .i_pop   (w_qpop)
    );

    // back sequencer
    epm_back #(
        .PW   (POSITION_WIDTH),
        .NW   (NORMAL_WIDTH),
        .CNTW (COUNT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (w_qstat),
        .i_qpos     (w_q_pos),
        .i_qnrm     (w_q_nrm),
        .o_qpop     (w_qpop),
        .i_md       (r_merge_dist),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pos      (w_o_pos),
        .o_nrm      (w_o_nrm),
        .o_run_end  (o_run_end),
        .o_seg_done (o_segment_done),
        .o_count    (o_merged_total)
    );

    assign o_out_x  = w_o_pos[0];
    assign o_out_y  = w_o_pos[1];
    assign o_out_z  = w_o_pos[2];
    assign o_out_nx = w_o_nrm[0];
    assign o_out_ny = w_o_nrm[1];
    assign o_out_nz = w_o_nrm[2];

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // segment end is always the last result of its transaction
    a_seg_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_segment_done |-> o_run_end)
        else $error("segment done without run end");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y)
        && $stable(o_out_z) && $stable(o_out_nx) && $stable(o_out_ny)
        && $stable(o_out_nz) && $stable(o_run_end) && $stable(o_segment_done)
        && $stable(o_merged_total))
        else $error("stalled result changed");

endmodule

FILE: dv/tb_edge_point_pair_merger_unit.sv
// self-checking testbench for the edge point pair merger
// depends on epm_pkg and edge_point_pair_merger_unit, which needs epm_front and epm_back
module tb_edge_point_pair_merger_unit import epm_pkg::*;;

    localparam int PW = 32;
    localparam int NW = 16;
    localparam int CW = 16;
    localparam int NF = NW - 2;

    typedef struct {
        logic signed [PW-1:0] x, y, z;
        logic signed [NW-1:0] nx, ny, nz;
        logic                 last;
    } t_point;

    typedef struct {
        logic signed [PW-1:0] x, y, z;
        logic signed [NW-1:0] nx, ny, nz;
        logic                 run_end;
        logic                 seg_done;
        logic [CW-1:0]        merged;
    } t_emitted;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [PW-1:0] i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic signed [NW-1:0] i_in_nx = '0, i_in_ny = '0, i_in_nz = '0;
    logic i_segment_last = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [PW-1:0] o_out_x, o_out_y, o_out_z;
    logic signed [NW-1:0] o_out_nx, o_out_ny, o_out_nz;
    logic o_run_end, o_segment_done;
    logic [CW-1:0] o_merged_total;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [MD_WIDTH-1:0] i_cfg_data = '0;

    edge_point_pair_merger_unit dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [MD_WIDTH-1:0]  md;
    logic signed [63:0]   prv_p[3], prv_n[3], last_em[3];
    bit                   have_prv, prv_absorbed, first_pending;
    logic [CW-1:0]        n_merged;

    t_point   pending_pts[$];
    t_emitted expected_pts[$];
    int       errors = 0;
    bit       quiet_end = 0;
    bit       long_hold = 0;
    int       accepted = 0;

    function automatic logic [63:0] sqrt_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void push_point(const ref logic signed [63:0] p[3],
                                       const ref logic signed [63:0] n[3]);
        t_emitted e;
        e.x = PW'(p[0]); e.y = PW'(p[1]); e.z = PW'(p[2]);
        e.nx = NW'(n[0]); e.ny = NW'(n[1]); e.nz = NW'(n[2]);
        e.run_end = 1'b0; e.seg_done = 1'b0; e.merged = '0;
        for (int i = 0; i < 3; i++) last_em[i] = p[i];
        expected_pts = {expected_pts, e};
    endfunction

    // work out the results of one accepted point
    function automatic void predict_merge(t_point pt);
        logic signed [63:0] cp[3], cn[3], mp[3], mn[3], s[3];
        logic [63:0] q, len, m, d, sum, mdd;
        bit far, next_abs, same;
        int first_new, cnt;
        first_new = expected_pts.size();
        cp[0] = 64'(pt.x); cp[1] = 64'(pt.y); cp[2] = 64'(pt.z);
        cn[0] = 64'(pt.nx); cn[1] = 64'(pt.ny); cn[2] = 64'(pt.nz);
        mdd = 64'(md);
        if (have_prv) begin
            next_abs = 0;
            if (!prv_absorbed) begin
                far = 0; sum = 0;
                for (int i = 0; i < 3; i++) begin
                    d = mag(cp[i] - prv_p[i]);
                    if (d > mdd) far = 1;
                    sum += d * d;
                end
                if (!far) far = sum > mdd * mdd;
                if (far) begin
                    push_point(prv_p, prv_n);
                end else begin
                    q = 0;
                    for (int i = 0; i < 3; i++) begin
                        mp[i] = (prv_p[i] + cp[i]) >>> 1;
                        s[i] = prv_n[i] + cn[i];
                        q += mag(s[i]) * mag(s[i]);
                    end
                    if (q == 0) begin
                        for (int i = 0; i < 3; i++) mn[i] = 0;
                    end else begin
                        len = sqrt_floor(q);
                        for (int i = 0; i < 3; i++) begin
                            m = ((mag(s[i]) << (NF + 1)) + len) / (2 * len);
                            if (m > (64'd1 << NF)) m = 64'd1 << NF;
                            mn[i] = s[i] < 0 ? -$signed(m) : $signed(m);
                        end
                    end
                    same = mp[0] == prv_p[0] && mp[1] == prv_p[1] && mp[2] == prv_p[2];
                    if (first_pending && !same) push_point(prv_p, prv_n);
                    push_point(mp, mn);
                    if (n_merged != '1) n_merged++;
                    next_abs = 1;
                end
                first_pending = 0;
            end
            if (pt.last) begin
                same = cp[0] == last_em[0] && cp[1] == last_em[1] && cp[2] == last_em[2];
                if (!same) push_point(cp, cn);
            end else begin
                prv_p = cp; prv_n = cn;
                prv_absorbed = next_abs;
            end
        end else if (pt.last) begin
            push_point(cp, cn);
        end else begin
            prv_p = cp; prv_n = cn;
            have_prv = 1; prv_absorbed = 0;
        end
        cnt = expected_pts.size();
        for (int i = first_new; i < cnt; i++) expected_pts[i].merged = n_merged;
        if (cnt > first_new) begin
            expected_pts[cnt-1].run_end = 1'b1;
            expected_pts[cnt-1].seg_done = pt.last;
        end
        if (pt.last) begin
            for (int i = 0; i < 3; i++) begin
                prv_p[i] = 0; prv_n[i] = 0;
            end
            have_prv = 0; prv_absorbed = 0; first_pending = 1; n_merged = '0;
        end
    endfunction

    // input driver with random gap bursts
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_point nxt;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_merge(pending_pts.pop_front());
                accepted++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (!quiet_end && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 11) - 1;
                    i_valid <= 1'b0;
                end else if (pending_pts.size() > 0) begin
                    nxt = pending_pts[0];
                    i_valid <= 1'b1;
                    i_in_x <= nxt.x; i_in_y <= nxt.y; i_in_z <= nxt.z;
                    i_in_nx <= nxt.nx; i_in_ny <= nxt.ny; i_in_nz <= nxt.nz;
                    i_segment_last <= nxt.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stall
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_emitted e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_pts.size() == 0) begin
                    $display("%0t: mismatch expected none, actual x=%h y=%h z=%h", $time,
                             o_out_x, o_out_y, o_out_z);
                    errors++;
                end else begin
                    e = expected_pts.pop_front();
                    if (o_out_x !== e.x || o_out_y !== e.y || o_out_z !== e.z ||
                        o_out_nx !== e.nx || o_out_ny !== e.ny || o_out_nz !== e.nz ||
                        o_run_end !== e.run_end || o_segment_done !== e.seg_done ||
                        o_merged_total !== e.merged) begin
                        $display("%0t: mismatch expected %h %h %h n %h %h %h e%b d%b m%0d",
                                 $time, e.x, e.y, e.z, e.nx, e.ny, e.nz,
                                 e.run_end, e.seg_done, e.merged);
                        $display("%0t:          actual %h %h %h n %h %h %h e%b d%b m%0d",
                                 $time, o_out_x, o_out_y, o_out_z, o_out_nx, o_out_ny,
                                 o_out_nz, o_run_end, o_segment_done, o_merged_total);
                        errors++;
                    end
                end
            end
            if (long_hold) begin
                stall_left = 300;
                long_hold = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet_end && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic [NW-1:0] rand_normal();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return NW'($urandom);
        if (r == 1) return 16'sd16384;
        if (r == 2) return -16'sd16384;
        return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    function automatic t_point near_point(t_point base, int spread, bit last);
        t_point p;
        p = base;
        p.x = base.x + $signed($urandom_range(0, 2 * spread)) - spread;
        p.y = base.y + $signed($urandom_range(0, 2 * spread)) - spread;
        p.z = base.z + $signed($urandom_range(0, 2 * spread)) - spread;
        p.nx = rand_normal(); p.ny = rand_normal(); p.nz = rand_normal();
        p.last = last;
        return p;
    endfunction

    task automatic add_pt(logic signed [PW-1:0] x, y, z, logic signed [NW-1:0] nx, ny, nz,
                          bit last);
        t_point p;
        p.x = x; p.y = y; p.z = z; p.nx = nx; p.ny = ny; p.nz = nz; p.last = last;
        pending_pts = {pending_pts, p};
    endtask

    task automatic settle();
        while (pending_pts.size() > 0 || i_valid || expected_pts.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_distance(logic [MD_WIDTH-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        md = v;
    endtask

    // random segments: mostly clustered walks, some far jumps
    task automatic random_segments(int n_items, int spread);
        t_point base;
        int len, made;
        made = 0;
        while (made < n_items) begin
            len = $urandom_range(1, 9);
            base.x = $urandom; base.y = $urandom; base.z = $urandom;
            if ($urandom_range(0, 3) != 0) begin
                base.x = base.x >>> 8; base.y = base.y >>> 8; base.z = base.z >>> 8;
            end
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 6) == 0) base = near_point(base, 2 * spread + 1000, 0);
                else base = near_point(base, spread, 0);
                base.last = (k == len - 1);
                if ($urandom_range(0, 9) == 0) base = pending_pts.size() > 0 ?
                    pending_pts[$] : base;
                base.last = (k == len - 1);
                pending_pts = {pending_pts, base};
            end
            made += len;
        end
    endtask

    initial begin
        md = 0;
        for (int i = 0; i < 3; i++) begin
            prv_p[i] = 0; prv_n[i] = 0; last_em[i] = 0;
        end
        have_prv = 0; prv_absorbed = 0; first_pending = 1; n_merged = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lone point, zero distance, duplicates, extremes
        add_pt(32'sh7fffffff, 32'sh80000000, 0, 16'sd16384, -16'sd16384, 0, 1);
        add_pt(5, 5, 5, 16'sd16384, 0, 0, 0);
        add_pt(5, 5, 5, -16'sd16384, 0, 0, 0);
        add_pt(5, 5, 5, 0, 16'sd16384, 0, 1);
        add_pt(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'h8000, 16'h7fff, 0, 0);
        add_pt(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'hffff, 0, 16'h8000, 1);
        settle();
        write_distance('1);
        // maximum merge distance: extreme positions stay apart, near pairs merge; odd negative sums
        add_pt(32'sh80000000, 32'sh7fffffff, -3, 16'sd16384, 0, 0, 0);
        add_pt(32'sh7fffffff, 32'sh80000000, 0, -16'sd16384, 0, 0, 0);
        add_pt(-7, 9, 1, 0, 0, 16'sd16384, 0);
        add_pt(-8, 9, 1, 0, 16'sd16384, 0, 0);
        add_pt(-9, 9, 1, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        add_pt(-9, 9, 1, 16'h7fff, 16'h7fff, 16'h7fff, 1);
        add_pt(0, 0, 0, 1, 0, 0, 0);
        add_pt(0, 0, 0, 1, 0, 0, 1);
        settle();
        write_distance(31'h0001_0000);
        add_pt(0, 0, 0, 16'sd16384, 0, 0, 0);
        add_pt(32'sh0000_ffff, 0, 0, 16'sd16384, 0, 0, 0);
        add_pt(32'sh0003_0000, 0, 0, 0, 16'sd16384, 0, 0);
        add_pt(32'sh0003_b000, 32'sh0000_b000, 32'sh0000_b000, 0, 16'sd16384, 0, 0);
        add_pt(32'sh0010_0000, 0, 0, 0, 0, 16'sd16384, 1);
        settle();

        // random with a mid distance, including a long receiver hold
        write_distance(31'h0000_8000);
        random_segments(25, 32'h8000);
        long_hold = 1;
        random_segments(25, 32'h8000);
        settle();
        write_distance(31'h0010_0000);
        random_segments(40, 32'h0010_0000);
        settle();
        write_distance('1);
        random_segments(15, 32'h0100_0000);
        settle();
        write_distance(0);
        random_segments(15, 4);
        settle();
        write_distance(31'h0004_0000);
        quiet_end = 1;
        random_segments(15, 32'h0004_0000);
        settle();

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/epm_pkg.sv
src/epm_front.sv
src/epm_back.sv
src/edge_point_pair_merger_unit.sv
dv/tb_edge_point_pair_merger_unit.sv
